@@ rtl/netchan_payload_word_scrambler_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the payload word scrambler.
// Shared property shapes used by the top level of the block.
// ---------------------------------------------------------------------------
`ifndef NETCHAN_PAYLOAD_WORD_SCRAMBLER_CORE_DEFINES_SVH
`define NETCHAN_PAYLOAD_WORD_SCRAMBLER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPWS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/npws_pkg.sv @@
// ---------------------------------------------------------------------------
// Payload word scrambler package
// Shared types, the byte mask table and the word scrambling functions.
// ---------------------------------------------------------------------------
package npws_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] MASK_BASE = 8'hA5;

   localparam logic [7:0] MASK_TABLE [16] = '{
      8'h05, 8'h61, 8'h7a, 8'hed, 8'h1b, 8'hca, 8'h0d, 8'h9b,
      8'h4a, 8'hf1, 8'h64, 8'hc7, 8'hb5, 8'h8e, 8'hdf, 8'ha0
   };

   // One group of up to four output bytes, little-endian in the word.
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  last_idx;
      logic        last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [31:0] word_mask(input logic [3:0] wc);
      logic [31:0] m;
      logic [3:0]  ti;
      m  = '0;
      ti = '0;
      for (int i = 0; i < 4; i++) begin
         ti = wc + 4'(i);
         m[i*8 +: 8] = MASK_BASE | 8'(i << i) | 8'(i) | MASK_TABLE[ti];
      end
      return m;
   endfunction

   function automatic logic [31:0] scramble(input logic [31:0] v, input logic [7:0] key,
                                            input logic [3:0] wc, input logic enc);
      logic [31:0] k;
      logic [31:0] nk;
      logic [31:0] m;
      k  = {24'h000000, key};
      nk = ~k;
      m  = word_mask(wc);
      if (enc) begin
         return swap_bytes(v ^ nk) ^ m ^ k;
      end else begin
         return swap_bytes(v ^ k ^ m) ^ nk;
      end
   endfunction

endpackage

@@ rtl/npws_front.sv @@
// ---------------------------------------------------------------------------
// Payload word scrambler front end
// Accepts payload bytes into four-byte groups; scrambles full groups only.
// ---------------------------------------------------------------------------
module npws_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_data_byte,
   input  logic [7:0]                  req_seq_key,
   input  logic                        req_last_byte,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic                        csr_encode_mode,
   input  npws_pkg::queue_status_type  q_status,
   output logic                        push,
   output npws_pkg::group_type         push_entry
);

   logic [7:0] hold_ff [3];
   logic [7:0] hold_in [3];
   logic [1:0] hold_count_ff, hold_count_in;
   logic [3:0] word_count_ff, word_count_in;
   logic [7:0] key_ff, key_in;
   logic       in_packet_ff, in_packet_in;
   logic       encode_ff, encode_in;
   logic       accept;
   logic [7:0] key_eff;
   logic [31:0] pass_word;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hold_in       = hold_ff;
      hold_count_in = hold_count_ff;
      word_count_in = word_count_ff;
      key_in        = key_ff;
      in_packet_in  = in_packet_ff;
      encode_in     = encode_ff;
      push          = 1'b0;
      push_entry    = '0;
      key_eff       = in_packet_ff ? key_ff : req_seq_key;
      pass_word     = {req_data_byte, hold_ff[2], hold_ff[1], hold_ff[0]};
      pass_word[{hold_count_ff, 3'b000} +: 8] = req_data_byte;

      if (csr_valid && csr_ready) begin
         encode_in = csr_encode_mode;
      end

      if (accept) begin
         key_in       = key_eff;
         in_packet_in = 1'b1;
         if (hold_count_ff == 2'd3) begin
            push                = 1'b1;
            push_entry.word     = npws_pkg::scramble(pass_word, key_eff, word_count_ff,
                                                     encode_ff);
            push_entry.last_idx = 2'd3;
            push_entry.last     = req_last_byte;
            hold_count_in       = 2'd0;
            word_count_in       = word_count_ff + 4'd1;
         end else if (req_last_byte) begin
            push                = 1'b1;
            push_entry.word     = pass_word;
            push_entry.last_idx = hold_count_ff;
            push_entry.last     = 1'b1;
         end else begin
            hold_in[hold_count_ff] = req_data_byte;
            hold_count_in          = hold_count_ff + 2'd1;
         end
         if (req_last_byte) begin
            hold_count_in = 2'd0;
            word_count_in = 4'd0;
            in_packet_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      key_ff  <= key_in;
      if (reset) begin
         hold_count_ff <= 2'd0;
         word_count_ff <= 4'd0;
         in_packet_ff  <= 1'b0;
         encode_ff     <= 1'b1;
      end else begin
         hold_count_ff <= hold_count_in;
         word_count_ff <= word_count_in;
         in_packet_ff  <= in_packet_in;
         encode_ff     <= encode_in;
      end
   end

endmodule

@@ rtl/npws_queue.sv @@
// ---------------------------------------------------------------------------
// Payload word scrambler group queue
// A short first-in first-out queue of byte groups between front and back.
// ---------------------------------------------------------------------------
module npws_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  npws_pkg::group_type         push_entry,
   input  logic                        pop,
   output npws_pkg::group_type         head,
   output npws_pkg::queue_status_type  q_status
);

   npws_pkg::group_type entries_ff [npws_pkg::QUEUE_DEPTH];
   logic [npws_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [npws_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [npws_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign head           = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == (npws_pkg::QUEUE_AW+1)'(npws_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/npws_back.sv @@
// ---------------------------------------------------------------------------
// Payload word scrambler back end
// Unpacks queued groups into single output bytes behind an output register.
// ---------------------------------------------------------------------------
module npws_back (
   input  logic                        clock,
   input  logic                        reset,
   input  npws_pkg::group_type         head,
   input  npws_pkg::queue_status_type  q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       advance;
   logic       at_end;

   assign advance = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign at_end  = (idx_ff == head.last_idx);
   assign pop     = advance && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = head.word[{idx_ff, 3'b000} +: 8];
         rsp_last_in  = head.last && at_end;
         idx_in       = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

@@ rtl/netchan_payload_word_scrambler_core.sv @@
// Path: a byte that completes a group or ends a packet writes the group into the queue; the
// group's first byte then enters the output register; the rest follow one per cycle unless stalled.
// Throughput: one input byte per cycle unless the queue is full and one output byte per cycle
// unless rsp_ready stalls it, set by the back end; a four-group queue absorbs bursts.
// Reset: synchronous, active high; clears the queue, the counters and the packet state,
// and sets the encode mode to 1.
// ---------------------------------------------------------------------------
// Payload word scrambler core
// Scrambles or unscrambles packet payload bytes in full little-endian four-byte words.
// ---------------------------------------------------------------------------
`include "netchan_payload_word_scrambler_core_defines.svh"

module netchan_payload_word_scrambler_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_seq_key,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_encode_mode
);

   npws_pkg::queue_status_type q_status;
   npws_pkg::group_type        push_entry;
   npws_pkg::group_type        head;
   logic                       push;
   logic                       pop;

   assign csr_ready = 1'b1;

   npws_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_seq_key     (req_seq_key),
      .req_last_byte   (req_last_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_encode_mode (csr_encode_mode),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   npws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   npws_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   `NPWS_ASSERT_SAME(a_no_push_when_full, clock, reset, push, !q_status.full, "Group pushed into a full queue.")
   `NPWS_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, !q_status.empty, "Group popped from an empty queue.")
   `NPWS_ASSERT_NEXT(a_back_drains, clock, reset, !q_status.empty && !rsp_valid, rsp_valid, "Queued group not moved to the output register.")

endmodule
